[design/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants for the cooperative tick task scheduler: field widths,
// command codes and default sizes.
// ----------------------------------------------------------------------------
package cts_pkg;

  // Default sizes
  localparam int DEF_SLOTS     = 8;
  localparam int DEF_TICK_BITS = 16;
  localparam int DEF_RUN_BITS  = 8;

  // Most results one dispatch may give
  localparam int MAX_RESULTS   = 8;
  localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

  // Beat field widths
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 3;
  localparam int FIELD_W  = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd3;

endpackage

[design/cts_if.sv]
// ----------------------------------------------------------------------------
// cts_in_if / cts_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface cts_in_if;
  logic                         valid;
  logic                         ready;
  logic [cts_pkg::CMD_W-1:0]    cmd;
  logic [cts_pkg::SLOT_W-1:0]   slot;
  logic [cts_pkg::FIELD_W-1:0]  delay;
  logic [cts_pkg::FIELD_W-1:0]  period;

  modport source (output valid, cmd, slot, delay, period, input ready);
  modport sink   (input valid, cmd, slot, delay, period, output ready);
endinterface

interface cts_out_if;
  logic                         valid;
  logic                         ready;
  logic [cts_pkg::SLOT_W-1:0]   run_slot;
  logic                         run_valid;
  logic                         last;

  modport source (output valid, run_slot, run_valid, last, input ready);
  modport sink   (input valid, run_slot, run_valid, last, output ready);
endinterface

[design/cts_ram.sv]
// ----------------------------------------------------------------------------
// cts_ram
// Slot table storage: one write port, one read port, registered read data
// that holds while no read is issued.
// ----------------------------------------------------------------------------
module cts_ram #(
  parameter int DEPTH = cts_pkg::DEF_SLOTS,
  parameter int WIDTH = 2 * cts_pkg::DEF_TICK_BITS + cts_pkg::DEF_RUN_BITS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[design/cts_ctrl.sv]
// ----------------------------------------------------------------------------
// cts_ctrl
// Command sequencer: takes command beats, walks the slot table through the
// RAM (read one slot, then update it and write it back from the update
// stage), keeps the slot valid bits and drives the result register.
// ----------------------------------------------------------------------------
module cts_ctrl #(
  parameter int SLOTS     = cts_pkg::DEF_SLOTS,
  parameter int TICK_BITS = cts_pkg::DEF_TICK_BITS,
  parameter int RUN_BITS  = cts_pkg::DEF_RUN_BITS
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  cts_in_if.sink                                     in_i,
  cts_out_if.source                                  out_o,
  output logic                                       ram_we_o,
  output logic [$clog2(SLOTS)-1:0]                   ram_waddr_o,
  output logic [2*TICK_BITS+RUN_BITS-1:0]            ram_wdata_o,
  output logic                                       ram_re_o,
  output logic [$clog2(SLOTS)-1:0]                   ram_raddr_o,
  input  logic [2*TICK_BITS+RUN_BITS-1:0]            ram_rdata_i
);

  localparam int AddrW = $clog2(SLOTS);
  localparam int EntW  = 2 * TICK_BITS + RUN_BITS;
  localparam int ResW  = cts_pkg::RES_CNT_W;
  localparam logic [AddrW-1:0] LastSlot = AddrW'(SLOTS - 1);
  localparam logic [ResW-1:0]  MaxRes   = ResW'(cts_pkg::MAX_RESULTS);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                  state_q;
  logic [cts_pkg::CMD_W-1:0]   cmd_q;
  logic [AddrW-1:0]            a_q;
  logic                        a_act_q;
  logic                        b_v_q;
  logic [AddrW-1:0]            b_slot_q;
  logic                        hold_v_q;
  logic [cts_pkg::SLOT_W-1:0]  hold_slot_q;
  logic [ResW-1:0]             n_q;
  logic [SLOTS-1:0]            valid_q;
  logic                        out_v_q;
  logic [cts_pkg::SLOT_W-1:0]  out_slot_q;
  logic                        out_run_q;
  logic                        out_last_q;

  logic                  in_fire;
  logic                  slot_ok;
  logic [AddrW-1:0]      in_addr;
  logic [TICK_BITS-1:0]  in_delay;
  logic [TICK_BITS-1:0]  in_period;
  logic [TICK_BITS-1:0]  r_delay;
  logic [TICK_BITS-1:0]  r_period;
  logic [RUN_BITS-1:0]   r_runs;
  logic [TICK_BITS-1:0]  n_delay;
  logic [RUN_BITS-1:0]   n_runs;
  logic                  is_disp;
  logic                  b_live;
  logic                  take;
  logic                  out_free;
  logic                  stall;
  logic                  adv;
  logic                  walk_done;
  logic                  push_mid;
  logic                  push_fin;

  // Input beat decode
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_ok    = {29'd0, in_i.slot} < 32'(SLOTS);
  assign in_addr    = AddrW'(in_i.slot);
  assign in_delay   = TICK_BITS'(32'(in_i.delay));
  assign in_period  = TICK_BITS'(32'(in_i.period));

  // Entry fields of the slot in the update stage
  assign r_delay  = ram_rdata_i[EntW-1 -: TICK_BITS];
  assign r_period = ram_rdata_i[RUN_BITS+TICK_BITS-1 -: TICK_BITS];
  assign r_runs   = ram_rdata_i[RUN_BITS-1:0];

  assign is_disp  = (cmd_q == cts_pkg::CMD_DISPATCH);
  assign b_live   = b_v_q && valid_q[b_slot_q];
  assign take     = is_disp && b_live && (r_runs != '0) && (n_q < MaxRes);
  assign out_free = !out_v_q || out_o.ready;

  // A second ready slot pushes the held one out; wait if the result register is busy
  assign stall     = take && hold_v_q && !out_free;
  assign adv       = (state_q == S_WALK) && !stall;
  assign walk_done = adv && b_v_q && (b_slot_q == LastSlot);
  assign push_mid  = adv && take && hold_v_q;
  assign push_fin  = (state_q == S_FIN) && out_free;

  // Slot update: tick countdown / run accrual, or dispatch decrement
  always_comb begin
    n_delay = r_delay;
    n_runs  = r_runs;
    if (is_disp) begin
      n_runs = r_runs - 1'b1;
    end else if (r_delay != '0) begin
      n_delay = r_delay - 1'b1;
    end else begin
      if (!(&r_runs)) begin
        n_runs = r_runs + 1'b1;
      end
      if (r_period != '0) begin
        n_delay = r_period - 1'b1;
      end
    end
  end

  // RAM ports
  always_comb begin
    if (state_q == S_IDLE) begin
      ram_we_o    = in_fire && (in_i.cmd == cts_pkg::CMD_ADD) && slot_ok;
      ram_waddr_o = in_addr;
      ram_wdata_o = {in_delay, in_period, {RUN_BITS{1'b0}}};
    end else begin
      ram_we_o    = adv && (is_disp ? take : b_live);
      ram_waddr_o = b_slot_q;
      ram_wdata_o = {n_delay, r_period, n_runs};
    end
  end
  assign ram_re_o    = adv && a_act_q;
  assign ram_raddr_o = a_q;

  // Sequencer and walk pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= cts_pkg::CMD_ADD;
      a_q         <= '0;
      a_act_q     <= 1'b0;
      b_v_q       <= 1'b0;
      b_slot_q    <= '0;
      hold_v_q    <= 1'b0;
      hold_slot_q <= '0;
      n_q         <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q    <= in_i.cmd;
            a_q      <= '0;
            a_act_q  <= 1'b1;
            b_v_q    <= 1'b0;
            hold_v_q <= 1'b0;
            n_q      <= '0;
            if (in_i.cmd inside {cts_pkg::CMD_TICK, cts_pkg::CMD_DISPATCH}) begin
              state_q <= S_WALK;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_WALK: begin
          if (adv) begin
            b_v_q    <= a_act_q;
            b_slot_q <= a_q;
            if (a_act_q) begin
              if (a_q == LastSlot) begin
                a_act_q <= 1'b0;
              end else begin
                a_q <= a_q + 1'b1;
              end
            end
            if (take) begin
              hold_v_q    <= 1'b1;
              hold_slot_q <= cts_pkg::SLOT_W'(b_slot_q);
              n_q         <= n_q + 1'b1;
            end
            if (walk_done) begin
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (push_fin) begin
            hold_v_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (in_fire && slot_ok) begin
      if (in_i.cmd == cts_pkg::CMD_ADD) begin
        valid_q[in_addr] <= 1'b1;
      end else if (in_i.cmd == cts_pkg::CMD_DELETE) begin
        valid_q[in_addr] <= 1'b0;
      end
    end else if (adv && take && (r_period == '0)) begin
      // one-shot task leaves the table after its run
      valid_q[b_slot_q] <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (push_mid || push_fin) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_mid) begin
      out_slot_q <= hold_slot_q;
      out_run_q  <= 1'b1;
      out_last_q <= 1'b0;
    end else if (push_fin) begin
      out_last_q <= 1'b1;
      if (is_disp && hold_v_q) begin
        out_slot_q <= hold_slot_q;
        out_run_q  <= 1'b1;
      end else begin
        out_slot_q <= '0;
        out_run_q  <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.run_slot  = out_slot_q;
  assign out_o.run_valid = out_run_q;
  assign out_o.last      = out_last_q;

endmodule

[design/cooperative_tick_task_scheduler.sv]
// ----------------------------------------------------------------------------
// cooperative_tick_task_scheduler
// Time-triggered cooperative scheduler over a table of priority-indexed slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries command beats (add, delete, tick, dispatch) with slot, delay
//   and period; results leave on out_o as run_slot/run_valid/last.
//   Add, delete and tick give one acknowledgement beat with last set. Dispatch
//   gives one beat per ready slot in slot order (0 first), last on the final
//   one, or a single beat with run_valid low when nothing is ready.
//   Add and delete go from the command beat straight to the finish state,
//   which loads their result once the result register is free. Tick and
//   dispatch walk the slot table through the RAM one slot per cycle while
//   no stall holds the walk, with registered read data, and then load the
//   final result from the finish state. One command is in work at a time;
//   the next beat is taken at the edge after the final result is loaded.
//   A stalled receiver holds the result register and the command in work; a
//   dispatch walk pauses on a second ready slot until the register frees up.
//   Reset clears all slot valid bits; the RAM needs no clearing since a slot's
//   counters are only used while the slot is valid.
// ----------------------------------------------------------------------------
module cooperative_tick_task_scheduler #(
  parameter int SLOTS     = cts_pkg::DEF_SLOTS,
  parameter int TICK_BITS = cts_pkg::DEF_TICK_BITS,
  parameter int RUN_BITS  = cts_pkg::DEF_RUN_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cts_in_if.sink     in_i,
  cts_out_if.source  out_o
);

  localparam int AddrW = $clog2(SLOTS);
  localparam int EntW  = 2 * TICK_BITS + RUN_BITS;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [EntW-1:0]   ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntW-1:0]   ram_rdata;

  // Slot counters storage
  cts_ram #(
    .DEPTH (SLOTS),
    .WIDTH (EntW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Command sequencer
  cts_ctrl #(
    .SLOTS     (SLOTS),
    .TICK_BITS (TICK_BITS),
    .RUN_BITS  (RUN_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

[sim/cooperative_tick_task_scheduler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cooperative_tick_task_scheduler_tb
// Self-checking bench for the tick task scheduler. Command beats go in
// through a valid/ready driver fed from a queue. A cycle-free model of the
// slot table predicts every result beat. A monitor checks each accepted
// result against the oldest prediction. The run steps through sender-heavy
// gaps, receiver-heavy stalls and full-rate traffic.
// ----------------------------------------------------------------------------
module cooperative_tick_task_scheduler_tb;

  localparam int N_SLOTS   = cts_pkg::DEF_SLOTS;
  localparam int TICK_BITS = cts_pkg::DEF_TICK_BITS;
  localparam int RUN_BITS  = cts_pkg::DEF_RUN_BITS;
  localparam logic [RUN_BITS-1:0] RUNS_SAT = {RUN_BITS{1'b1}};

  typedef struct packed {
    logic [cts_pkg::CMD_W-1:0]   cmd;
    logic [cts_pkg::SLOT_W-1:0]  slot;
    logic [cts_pkg::FIELD_W-1:0] delay;
    logic [cts_pkg::FIELD_W-1:0] period;
  } sched_cmd_t;

  typedef struct packed {
    logic [cts_pkg::SLOT_W-1:0] run_slot;
    logic                       run_valid;
    logic                       last;
  } run_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cts_in_if  cmd_if ();
  cts_out_if run_if ();

  cooperative_tick_task_scheduler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (run_if)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow slot table
  logic                 slot_armed   [N_SLOTS];
  logic [TICK_BITS-1:0] ticks_left   [N_SLOTS];
  logic [TICK_BITS-1:0] reload_ticks [N_SLOTS];
  logic [RUN_BITS-1:0]  runs_owed    [N_SLOTS];

  sched_cmd_t pending_cmds [$];
  run_beat_t  expected_runs [$];

  int beats_offered = 0;
  int beats_taken   = 0;
  int src_gap_pct   = 0;
  int sink_stall_pct = 0;
  int error_count   = 0;

  // Coverage tallies for the summary
  int cmd_count [4];
  int runs_seen      = 0;
  int idle_dispatch  = 0;
  int widest_dispatch = 0;

  // Apply one command to the shadow table and queue the beats it causes
  function automatic void schedule_step(input sched_cmd_t c);
    int        ready_slots [$];
    run_beat_t beat;
    ready_slots = {};
    cmd_count[c.cmd]++;
    case (c.cmd)
      cts_pkg::CMD_ADD: begin
        if (int'(c.slot) < N_SLOTS) begin
          slot_armed[c.slot]   = 1'b1;
          ticks_left[c.slot]   = c.delay[TICK_BITS-1:0];
          reload_ticks[c.slot] = c.period[TICK_BITS-1:0];
          runs_owed[c.slot]    = '0;
        end
      end
      cts_pkg::CMD_DELETE: begin
        if (int'(c.slot) < N_SLOTS) slot_armed[c.slot] = 1'b0;
      end
      cts_pkg::CMD_TICK: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          if (slot_armed[i]) begin
            if (ticks_left[i] != '0) begin
              ticks_left[i] = ticks_left[i] - 1'b1;
            end else begin
              if (runs_owed[i] != RUNS_SAT) runs_owed[i] = runs_owed[i] + 1'b1;
              if (reload_ticks[i] != '0) ticks_left[i] = reload_ticks[i] - 1'b1;
            end
          end
        end
      end
      default: begin
        // dispatch: each ready slot once, highest priority first
        for (int i = 0; i < N_SLOTS && ready_slots.size() < cts_pkg::MAX_RESULTS; i++) begin
          if (slot_armed[i] && runs_owed[i] != '0) begin
            ready_slots.push_back(i);
            runs_owed[i] = runs_owed[i] - 1'b1;
            if (reload_ticks[i] == '0) slot_armed[i] = 1'b0;
          end
        end
        if (ready_slots.size() > widest_dispatch) widest_dispatch = ready_slots.size();
        if (ready_slots.size() == 0) idle_dispatch++;
      end
    endcase
    if (ready_slots.size() == 0) begin
      beat = '{run_slot: '0, run_valid: 1'b0, last: 1'b1};
      expected_runs.push_back(beat);
    end else begin
      foreach (ready_slots[k]) begin
        beat.run_slot  = cts_pkg::SLOT_W'(ready_slots[k]);
        beat.run_valid = 1'b1;
        beat.last      = (k == ready_slots.size() - 1);
        expected_runs.push_back(beat);
      end
    end
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Driver: new beats and ready change on the falling edge
  always @(negedge clk_i) begin : drive_beats
    sched_cmd_t nxt;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      run_if.ready <= 1'b0;
    end else begin
      run_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (beats_taken == beats_offered) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
          nxt = pending_cmds.pop_front();
          cmd_if.valid  <= 1'b1;
          cmd_if.cmd    <= nxt.cmd;
          cmd_if.slot   <= nxt.slot;
          cmd_if.delay  <= nxt.delay;
          cmd_if.period <= nxt.period;
          beats_offered++;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result beats, then predict from accepted command beats
  always @(posedge clk_i) begin : watch_beats
    run_beat_t  got;
    run_beat_t  want;
    sched_cmd_t c;
    if (rst_ni) begin
      if (run_if.valid && run_if.ready) begin
        got = '{run_slot: run_if.run_slot, run_valid: run_if.run_valid, last: run_if.last};
        if (got.run_valid === 1'b1) runs_seen++;
        if (expected_runs.size() == 0) begin
          note_error($sformatf("unexpected result slot=%0d run_valid=%0b last=%0b",
                               got.run_slot, got.run_valid, got.last));
        end else begin
          want = expected_runs.pop_front();
          if (got.run_slot !== want.run_slot || got.run_valid !== want.run_valid ||
              got.last !== want.last)
            note_error($sformatf("result slot=%0d run_valid=%0b last=%0b, wanted %0d/%0b/%0b",
                                 got.run_slot, got.run_valid, got.last,
                                 want.run_slot, want.run_valid, want.last));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        c = '{cmd: cmd_if.cmd, slot: cmd_if.slot, delay: cmd_if.delay,
              period: cmd_if.period};
        schedule_step(c);
        beats_taken++;
      end
    end
  end

  task automatic push_cmd(input logic [cts_pkg::CMD_W-1:0] cmd, input int slot,
                          input int dly, input int per);
    sched_cmd_t c;
    c.cmd    = cmd;
    c.slot   = cts_pkg::SLOT_W'(slot);
    c.delay  = cts_pkg::FIELD_W'(dly);
    c.period = cts_pkg::FIELD_W'(per);
    pending_cmds.push_back(c);
  endtask

  // Push a command whose slot/delay/period fields are don't-care
  task automatic push_bare(input logic [cts_pkg::CMD_W-1:0] cmd);
    push_cmd(cmd, $urandom_range(N_SLOTS - 1), $urandom, $urandom);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || beats_taken != beats_offered ||
           expected_runs.size() != 0)
      @(negedge clk_i);
  endtask

  // Random traffic: mostly short timers so runs actually come due
  task automatic plan_random(input int n_items);
    int made;
    int pick;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        // fill every slot with a short periodic task, then run them all
        for (int s = 0; s < N_SLOTS; s++)
          push_cmd(cts_pkg::CMD_ADD, s, $urandom_range(1), $urandom_range(1, 3));
        push_bare(cts_pkg::CMD_TICK);
        push_bare(cts_pkg::CMD_TICK);
        push_bare(cts_pkg::CMD_DISPATCH);
        made += N_SLOTS + 3;
      end else if (pick < 23) begin
        if ($urandom_range(3) == 0)
          push_cmd(cts_pkg::CMD_ADD, $urandom_range(N_SLOTS - 1), $urandom, $urandom);
        else
          push_cmd(cts_pkg::CMD_ADD, $urandom_range(N_SLOTS - 1), $urandom_range(3),
                   $urandom_range(4));
        made++;
      end else if (pick < 31) begin
        push_cmd(cts_pkg::CMD_DELETE, $urandom_range(N_SLOTS - 1), $urandom, $urandom);
        made++;
      end else if (pick < 67) begin
        push_bare(cts_pkg::CMD_TICK);
        made++;
      end else begin
        push_bare(cts_pkg::CMD_DISPATCH);
        made++;
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.cmd    = cts_pkg::CMD_TICK;
    cmd_if.slot   = '0;
    cmd_if.delay  = '0;
    cmd_if.period = '0;
    run_if.ready  = 1'b0;
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_armed[i]   = 1'b0;
      ticks_left[i]   = '0;
      reload_ticks[i] = '0;
      runs_owed[i]    = '0;
    end
    foreach (cmd_count[k]) cmd_count[k] = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, one-shot vs periodic, field extremes,
    // deleted and re-added slots, overwrite with pending runs
    src_gap_pct    = 22;
    sink_stall_pct = 84;
    push_bare(cts_pkg::CMD_DISPATCH);                    // nothing ready
    push_bare(cts_pkg::CMD_TICK);                        // tick on empty table
    push_cmd(cts_pkg::CMD_DELETE, 5, 0, 0);              // delete an empty slot
    push_cmd(cts_pkg::CMD_ADD, 7, 0, 0);                 // one-shot, due at once
    push_cmd(cts_pkg::CMD_ADD, 0, 1, 2);
    push_cmd(cts_pkg::CMD_ADD, 2, 0, 1);                 // due every tick
    push_cmd(cts_pkg::CMD_ADD, 3, 16'hFFFF, 16'hFFFF);
    push_cmd(cts_pkg::CMD_ADD, 4, 16'hAAAA, 16'h5555);
    push_bare(cts_pkg::CMD_TICK);
    push_bare(cts_pkg::CMD_TICK);
    push_bare(cts_pkg::CMD_DISPATCH);                    // several slots, one run each
    push_bare(cts_pkg::CMD_DISPATCH);                    // slot 2 still owes a run
    push_bare(cts_pkg::CMD_TICK);
    push_cmd(cts_pkg::CMD_DELETE, 2, 16'h5555, 16'hAAAA);
    push_bare(cts_pkg::CMD_DISPATCH);                    // deleted slot is skipped
    push_cmd(cts_pkg::CMD_ADD, 2, 0, 0);                 // re-add clears old count
    push_bare(cts_pkg::CMD_TICK);
    push_cmd(cts_pkg::CMD_ADD, 0, 0, 0);                 // overwrite live slot
    push_bare(cts_pkg::CMD_DISPATCH);
    push_cmd(cts_pkg::CMD_DELETE, 3, 0, 0);
    push_cmd(cts_pkg::CMD_DELETE, 4, 0, 0);
    push_cmd(cts_pkg::CMD_DELETE, 6, 0, 0);
    wait_drained();

    // Random, sender gaps light and receiver stalls heavy
    plan_random(50);
    wait_drained();

    // Random, the other way round
    src_gap_pct    = 84;
    sink_stall_pct = 22;
    plan_random(50);
    wait_drained();

    // Full rate: random traffic, then build a backlog of runs on two slots
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    plan_random(50);
    push_cmd(cts_pkg::CMD_ADD, 1, 0, 1);
    push_cmd(cts_pkg::CMD_ADD, 6, 0, 0);
    repeat (12) push_bare(cts_pkg::CMD_TICK);
    repeat (3) push_bare(cts_pkg::CMD_DISPATCH);
    wait_drained();
    repeat (4 * (N_SLOTS + 2)) @(posedge clk_i);

    $display("Run covered %0d adds, %0d deletes, %0d ticks, %0d dispatches",
             cmd_count[cts_pkg::CMD_ADD], cmd_count[cts_pkg::CMD_DELETE],
             cmd_count[cts_pkg::CMD_TICK], cmd_count[cts_pkg::CMD_DISPATCH]);
    $display("  %0d task runs, %0d empty dispatches, widest dispatch %0d runs",
             runs_seen, idle_dispatch, widest_dispatch);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors", error_count);
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", expected_runs.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
design/cts_pkg.sv
design/cts_if.sv
design/cts_ram.sv
design/cts_ctrl.sv
design/cooperative_tick_task_scheduler.sv
sim/cooperative_tick_task_scheduler_tb.sv
